// ===== rtl/core/upbt_pkg.sv =====
package upbt_pkg;

  // request kinds
  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;
  localparam logic [1:0] REQ_BIND  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BOUND    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int SLOT_W = 3;
  localparam int PORT_W = 16;
  localparam int TAG_W  = 8;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] slot_in;
    logic [PORT_W-1:0] port_in;
    logic [TAG_W-1:0]  tag_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic [TAG_W-1:0]  tag_out;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // search, update the table, register the result
  } cmd_t;

endpackage

// ===== rtl/core/upbt_datapath.sv =====
module upbt_datapath #(
  parameter int TABLE_ENTRIES = 8,
  parameter int STORE_W       = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  upbt_pkg::cmd_t    cmd,
  input  upbt_pkg::req_t    req,
  output upbt_pkg::rsp_t    rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  upbt_pkg::req_t req_q;

  logic [TABLE_ENTRIES-1:0] used;
  logic [upbt_pkg::PORT_W-1:0] port [TABLE_ENTRIES];
  logic [STORE_W-1:0]          tag  [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] clash_vec;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         match_idx;
  logic [IDX_W-1:0]         slot_idx;
  logic                     slot_ok;
  upbt_pkg::rsp_t           rsp_next;

  assign slot_idx = IDX_W'(req_q.slot_in);
  assign slot_ok  = 32'(req_q.slot_in) < 32'(TABLE_ENTRIES);

  // parallel compare of every entry
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      free_vec[i]  = ~used[i];
      match_vec[i] = used[i] && (port[i] == req_q.port_in);
      clash_vec[i] = match_vec[i] && (IDX_W'(i) != slot_idx);
    end
  end

  // lowest-index priority encoders
  always_comb begin
    free_idx  = '0;
    match_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    case (req_q.req_type)
      upbt_pkg::REQ_OPEN: begin
        if (|free_vec) begin
          rsp_next.slot_out = upbt_pkg::SLOT_W'(free_idx);
        end else begin
          rsp_next.status = upbt_pkg::ST_FULL;
        end
      end
      upbt_pkg::REQ_CLOSE: begin
        if (!slot_ok) begin
          rsp_next.status = upbt_pkg::ST_NOTFOUND;
        end
      end
      upbt_pkg::REQ_FIND: begin
        if (|match_vec) begin
          rsp_next.slot_out = upbt_pkg::SLOT_W'(match_idx);
          rsp_next.tag_out  = upbt_pkg::TAG_W'(tag[match_idx]);
        end else begin
          rsp_next.status = upbt_pkg::ST_NOTFOUND;
        end
      end
      upbt_pkg::REQ_BIND: begin
        if (!slot_ok) begin
          rsp_next.status = upbt_pkg::ST_NOTFOUND;
        end else if (|clash_vec) begin
          rsp_next.status = upbt_pkg::ST_BOUND;
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  // port and tag are only read for used entries, so they need no reset
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (req_q.req_type)
        upbt_pkg::REQ_OPEN: begin
          if (|free_vec) begin
            port[free_idx] <= '0;
            tag[free_idx]  <= STORE_W'(req_q.tag_in);
          end
        end
        upbt_pkg::REQ_BIND: begin
          if (slot_ok && !(|clash_vec)) begin
            port[slot_idx] <= req_q.port_in;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      case (req_q.req_type)
        upbt_pkg::REQ_OPEN: begin
          if (|free_vec) begin
            used[free_idx] <= 1'b1;
          end
        end
        upbt_pkg::REQ_CLOSE: begin
          if (slot_ok) begin
            used[slot_idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/upbt_ctrl.sv =====
module upbt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output upbt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign busy     = (state == S_EXEC);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted word not executed next cycle");

  a_exec_to_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done && !busy)
    else $error("execute cycle not followed by result strobe");

  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.exec))
    else $error("result strobe without an execute cycle");

  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec)
    else $error("execute lasted more than one cycle");

endmodule

// ===== rtl/core/udp_port_binding_table_core.sv =====
// A word accepted at a rising edge (start high, busy low) is captured in the request
//   register; the execute state then registers its result on rsp with done high.
// A new word is not taken while busy; busy is high only for the execute cycle, and a
//   new word may be accepted in the same cycle its predecessor's result is strobed.
// The receiver cannot stall: done is a one-cycle strobe. Synchronous reset (rst) frees
//   every entry and clears the controller; no clearing pass is needed.
module udp_port_binding_table_core #(
  parameter int TABLE_ENTRIES = 8,
  parameter int TAG_BITS      = 8
) (
  input  logic           clk,
  input  logic           rst,
  // request side
  input  logic           start,
  output logic           busy,
  input  upbt_pkg::req_t req,
  // result side
  output logic           done,
  output upbt_pkg::rsp_t rsp
);

  // tag_in is 8 bits wide, so at most 8 tag bits are ever stored
  localparam int STORE_W = (TAG_BITS < upbt_pkg::TAG_W) ? TAG_BITS : upbt_pkg::TAG_W;

  upbt_pkg::cmd_t cmd;

  // Controller: idle -> execute -> idle; strobes done after each execute cycle.
  upbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath: request register, entry table, parallel port compare with
  // lowest-index priority encoders, and the result register.
  upbt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STORE_W       (STORE_W)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int N_ENT     = 8;
  localparam int TAG_BITS  = 8;
  localparam int IDLE_MAX  = 2000;  // cycles with no accept and no strobe before giving up

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  upbt_pkg::req_t req = '0;
  upbt_pkg::rsp_t rsp;

  udp_port_binding_table_core #(
    .TABLE_ENTRIES(N_ENT),
    .TAG_BITS     (TAG_BITS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the binding table, kept in step with every accepted word.
  bit                          ent_used [N_ENT];
  logic [upbt_pkg::PORT_W-1:0] ent_port [N_ENT];
  logic [upbt_pkg::TAG_W-1:0]  ent_tag  [N_ENT];

  upbt_pkg::rsp_t rsp_due[$];      // results owed by the block, oldest first
  int   mismatch_cnt = 0;
  int   idle_cnt = 0;

  task automatic report_bad(string msg);
    $display("%0d ns: ERROR %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Applies one request to the shadow table and returns the result it owes.
  function automatic upbt_pkg::rsp_t predict_binding(upbt_pkg::req_t w);
    upbt_pkg::rsp_t r;
    int   s;
    bit   hit;
    r = '0;
    r.status = upbt_pkg::ST_OK;
    s = int'(w.slot_in);
    hit = 1'b0;
    case (w.req_type)
      upbt_pkg::REQ_OPEN: begin
        r.status = upbt_pkg::ST_FULL;
        for (int i = 0; i < N_ENT; i++) begin
          if (!hit && !ent_used[i]) begin
            hit = 1'b1;
            ent_used[i] = 1'b1;
            ent_port[i] = '0;
            ent_tag[i]  = w.tag_in & upbt_pkg::TAG_W'((64'd1 << TAG_BITS) - 1);
            r.status    = upbt_pkg::ST_OK;
            r.slot_out  = upbt_pkg::SLOT_W'(i);
          end
        end
      end
      upbt_pkg::REQ_CLOSE: begin
        // only the used flag drops; port and tag stay behind
        if (s < N_ENT) ent_used[s] = 1'b0;
        else r.status = upbt_pkg::ST_NOTFOUND;
      end
      upbt_pkg::REQ_FIND: begin
        r.status = upbt_pkg::ST_NOTFOUND;
        for (int i = 0; i < N_ENT; i++) begin
          if (!hit && ent_used[i] && ent_port[i] == w.port_in) begin
            hit = 1'b1;
            r.status   = upbt_pkg::ST_OK;
            r.slot_out = upbt_pkg::SLOT_W'(i);
            r.tag_out  = ent_tag[i];
          end
        end
      end
      default: begin  // bind
        if (s >= N_ENT) begin
          r.status = upbt_pkg::ST_NOTFOUND;
        end else begin
          // a free entry holding the port is not a conflict, nor is the target itself
          for (int i = 0; i < N_ENT; i++)
            if (i != s && ent_used[i] && ent_port[i] == w.port_in)
              r.status = upbt_pkg::ST_BOUND;
          if (r.status == upbt_pkg::ST_OK) ent_port[s] = w.port_in;  // even if slot is free
        end
      end
    endcase
    return r;
  endfunction

  function automatic upbt_pkg::req_t mk_req(logic [1:0] kind, int slot, int port, int tag);
    upbt_pkg::req_t w;
    w.req_type = kind;
    w.slot_in  = upbt_pkg::SLOT_W'(slot);
    w.port_in  = upbt_pkg::PORT_W'(port);
    w.tag_in   = upbt_pkg::TAG_W'(tag);
    return w;
  endfunction

  // Presents one word at the falling edge and holds it until the block takes it.
  // start is left high so back-to-back words need no extra edge.
  task automatic send_word(upbt_pkg::req_t w);
    @(negedge clk);
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    rsp_due.push_back(predict_binding(w));
  endtask

  // One sender gap; the request bus carries junk while start is low.
  task automatic idle_one();
    @(negedge clk);
    start <= 1'b0;
    req   <= upbt_pkg::req_t'($bits(upbt_pkg::req_t)'($urandom));
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_all_results();
    idle_one();
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  // Result checker: done is a one-cycle strobe, sampled at the rising edge.
  always @(posedge clk) begin
    upbt_pkg::rsp_t want;
    if (!rst && done === 1'b1) begin
      if (rsp_due.size() == 0) begin
        report_bad($sformatf("unexpected result status=%0d slot=%0d tag=%0h",
                             rsp.status, rsp.slot_out, rsp.tag_out));
      end else begin
        want = rsp_due.pop_front();
        if (rsp.status !== want.status)
          report_bad($sformatf("status got %0d want %0d", rsp.status, want.status));
        if (rsp.slot_out !== want.slot_out)
          report_bad($sformatf("slot_out got %0d want %0d", rsp.slot_out, want.slot_out));
        if (rsp.tag_out !== want.tag_out)
          report_bad($sformatf("tag_out got %0h want %0h", rsp.tag_out, want.tag_out));
      end
    end
  end

  // Watchdog: any accepted word or result strobe resets the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Fill all eight slots with edge-value tags, then one more open must report full.
  task automatic test_open_full();
    int tags [N_ENT] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h02, 8'h04, 8'h80};
    for (int i = 0; i < N_ENT; i++)
      send_word(mk_req(upbt_pkg::REQ_OPEN, 7 - i, 16'hFFFF, tags[i]));
    send_word(mk_req(upbt_pkg::REQ_OPEN, 0, 0, 8'h77));
  endtask

  // Port binding, conflicts and lookups on a full table.
  task automatic test_bind_find();
    send_word(mk_req(upbt_pkg::REQ_BIND, 0, 16'hFFFF, 0));
    send_word(mk_req(upbt_pkg::REQ_BIND, 3, 16'hFFFF, 8'hFF));  // held by slot 0 -> conflict
    send_word(mk_req(upbt_pkg::REQ_BIND, 0, 16'hFFFF, 0));      // rebinding own port is fine
    send_word(mk_req(upbt_pkg::REQ_FIND, 5, 16'hFFFF, 0));
    send_word(mk_req(upbt_pkg::REQ_FIND, 0, 16'h0000, 0));      // lowest used entry, port 0
    send_word(mk_req(upbt_pkg::REQ_FIND, 7, 16'h1234, 8'hFF));  // no match
    send_word(mk_req(upbt_pkg::REQ_BIND, 7, 16'h0001, 0));
  endtask

  // Close keeps port/tag, close of a free slot, bind to a free slot, reopen clears port.
  task automatic test_close_reuse();
    send_word(mk_req(upbt_pkg::REQ_CLOSE, 7, 0, 0));
    send_word(mk_req(upbt_pkg::REQ_FIND, 0, 16'h0001, 0));      // freed entry no longer matches
    send_word(mk_req(upbt_pkg::REQ_BIND, 5, 16'h0001, 0));      // only a free entry holds it
    send_word(mk_req(upbt_pkg::REQ_CLOSE, 7, 16'hFFFF, 8'hFF)); // already free
    send_word(mk_req(upbt_pkg::REQ_BIND, 7, 16'h8000, 0));      // free slot still takes the port
    send_word(mk_req(upbt_pkg::REQ_OPEN, 0, 0, 8'h3C));         // reuses slot 7, port back to 0
    send_word(mk_req(upbt_pkg::REQ_FIND, 0, 16'h8000, 0));
    send_word(mk_req(upbt_pkg::REQ_FIND, 0, 16'h0001, 0));
  endtask

  // Small port pool so finds hit and binds collide; the rest is full-range.
  function automatic logic [upbt_pkg::PORT_W-1:0] pick_port();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h8000;
      4: return 16'd53;
      5: return 16'h1234;
      default: return upbt_pkg::PORT_W'($urandom);
    endcase
  endfunction

  task automatic test_random(int n_words, int gap_pct);
    upbt_pkg::req_t w;
    int   pick;
    for (int k = 0; k < n_words; k++) begin
      while ($urandom_range(0, 99) < gap_pct) idle_one();
      pick = $urandom_range(0, 99);
      w.req_type = (pick < 28) ? upbt_pkg::REQ_OPEN : (pick < 50) ? upbt_pkg::REQ_CLOSE :
                   (pick < 75) ? upbt_pkg::REQ_FIND : upbt_pkg::REQ_BIND;
      w.slot_in  = upbt_pkg::SLOT_W'($urandom);
      w.port_in  = pick_port();
      w.tag_in   = upbt_pkg::TAG_W'($urandom);
      send_word(w);
    end
  endtask

  initial begin
    for (int i = 0; i < N_ENT; i++) begin
      ent_used[i] = 1'b0;
      ent_port[i] = '0;
      ent_tag[i]  = '0;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_open_full();
    test_bind_find();
    test_close_reuse();
    wait_all_results();

    // sender gaps 33%, then 80%, then back-to-back
    test_random(200, 33);
    wait_all_results();
    test_random(200, 80);
    wait_all_results();
    test_random(200, 0);
    wait_all_results();

    // leave a margin for any result still owed
    repeat (6) @(posedge clk);
    if (rsp_due.size() != 0) report_bad($sformatf("%0d results never arrived", rsp_due.size()));
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
